// ----- src/stack_calculator_core_top_macros.svh -----
// ---------------------------------------------------------------------------
// stack calculator assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef STACK_CALCULATOR_CORE_TOP_MACROS_SVH
`define STACK_CALCULATOR_CORE_TOP_MACROS_SVH

// same-cycle implication
`define SCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stack calculator check failed");

// next-cycle implication
`define SCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stack calculator check failed");

`endif

// ----- src/stkc_pkg.sv -----
// ---------------------------------------------------------------------------
// stkc_pkg
// widths, command and status codes shared by the stack calculator files
// ---------------------------------------------------------------------------
`default_nettype none

package stkc_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 3;
    localparam int TAG_W           = 3;
    localparam int STATUS_W        = 3;
    localparam int DEPTH_W         = 5;
    localparam int STACK_DEPTH_DEF = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRINT = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD  = 3'd4;

endpackage

`default_nettype wire

// ----- src/stkc_ram.sv -----
// ---------------------------------------------------------------------------
// stkc_ram
// generic ram, one write port and two registered read ports
// ---------------------------------------------------------------------------
`default_nettype none

module stkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ----- src/stkc_div.sv -----
// ---------------------------------------------------------------------------
// stkc_div
// signed divider truncating toward zero, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module stkc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [stkc_pkg::DATA_W-1:0] i_num,
    input  wire logic [stkc_pkg::DATA_W-1:0] i_den,
    output logic                             o_done,
    output logic      [stkc_pkg::DATA_W-1:0] o_quot
);

    localparam int DW = stkc_pkg::DATA_W;
    localparam int NW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic          r_neg;
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;
    logic          w_fit;

    // trial subtract of one restoring step
    assign w_shift = {r_rem, r_q[DW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    // iteration control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[DW-1] ^ i_den[DW-1];
                r_q    <= i_num[DW-1] ? (DW'(0) - i_num) : i_num;
                r_den  <= i_den[DW-1] ? (DW'(0) - i_den) : i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_fit ? w_diff[DW-1:0] : w_shift[DW-1:0];
                r_q   <= {r_q[DW-2:0], w_fit};
                r_cnt <= r_cnt + NW'(1);
                if (r_cnt == NW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (DW'(0) - r_q) : r_q;

endmodule

`default_nettype wire

// ----- src/stack_calculator_core_top.sv -----
// Push, add, sub, mul, print and any rejected command give their beat from S_EXEC,
// registered into o_done; a divide gives its beat from S_DIV once the divider is done.
// A new command is taken only in S_IDLE, not while busy; busy covers S_EXEC and,
// for a divide, S_DIV, which lasts for its 32-step bit-serial divider.
// Reset (synchronous, active low) empties the stack; the stack ram is not cleared.
// The result strobe o_done lasts one cycle and cannot be held off.
// ---------------------------------------------------------------------------
// stack_calculator_core_top
// stack machine calculator with its entries held in a synchronous ram
// ---------------------------------------------------------------------------
`default_nettype none

module stack_calculator_core_top #(
    parameter int STACK_DEPTH = stkc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic        [stkc_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic signed [stkc_pkg::DATA_W-1:0]   i_operand,
    output logic                                     busy,
    output logic                                     o_done,
    output logic             [stkc_pkg::STATUS_W-1:0] o_status,
    output logic                                     o_printed,
    output logic signed      [stkc_pkg::DATA_W-1:0]   o_print_value,
    output logic             [stkc_pkg::TAG_W-1:0]    o_print_tag,
    output logic             [stkc_pkg::DEPTH_W-1:0]  o_depth
);

    localparam int DW = stkc_pkg::DATA_W;
    localparam int TW = stkc_pkg::TAG_W;
    localparam int EW = TW + DW;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [stkc_pkg::CMD_W-1:0]      r_cmd, n_cmd;
    logic [DW-1:0]                   r_operand, n_operand;
    logic                            r_done, n_done;
    logic [stkc_pkg::STATUS_W-1:0]   r_status, n_status;
    logic                            r_printed, n_printed;
    logic [DW-1:0]                   r_pval, n_pval;
    logic [TW-1:0]                   r_ptag, n_ptag;
    logic [stkc_pkg::DEPTH_W-1:0]    r_depth, n_depth;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [AW-1:0] w_raddr_top;
    logic [AW-1:0] w_raddr_next;
    logic [EW-1:0] w_rd_top;
    logic [EW-1:0] w_rd_next;
    logic [DW-1:0] w_top;
    logic [DW-1:0] w_next;
    logic [DW-1:0] w_prod;
    logic [DW-1:0] w_alu;
    logic          w_div_start;
    logic          w_div_done;
    logic [DW-1:0] w_quot;

    // top two entries are always addressed; the read data is registered, so it is valid in the cycle after
    assign w_raddr_top  = AW'(r_count - CW'(1));
    assign w_raddr_next = AW'(r_count - CW'(2));

    stkc_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_top),
        .i_raddr_b (w_raddr_next),
        .o_rdata_a (w_rd_top),
        .o_rdata_b (w_rd_next)
    );

    assign w_top  = w_rd_top[DW-1:0];
    assign w_next = w_rd_next[DW-1:0];

    stkc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_top),
        .i_den   (w_next),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // add, sub and mul of top with next
    assign w_prod = w_top * w_next;

    always_comb begin
        unique case (r_cmd)
            stkc_pkg::CMD_ADD: w_alu = w_top + w_next;
            stkc_pkg::CMD_SUB: w_alu = w_top - w_next;
            default:           w_alu = w_prod;
        endcase
    end

    // command sequencing and stack update
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_operand   = r_operand;
        n_done      = 1'b0;
        n_status    = r_status;
        n_printed   = r_printed;
        n_pval      = r_pval;
        n_ptag      = r_ptag;
        n_depth     = r_depth;
        w_we        = 1'b0;
        w_waddr     = AW'(r_count - CW'(2));
        w_wdata     = {r_cmd, w_alu};
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_operand = i_operand;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state   = S_IDLE;
                n_done    = 1'b1;
                n_status  = stkc_pkg::ST_OK;
                n_printed = 1'b0;
                n_pval    = '0;
                n_ptag    = '0;
                priority if (r_cmd == stkc_pkg::CMD_PUSH) begin
                    if (r_operand == '1 || r_count >= CW'(STACK_DEPTH)) begin
                        n_status = stkc_pkg::ST_PUSH;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_count);
                        w_wdata = {TW'(0), r_operand};
                        n_count = r_count + CW'(1);
                    end
                end else if (r_cmd == stkc_pkg::CMD_ADD || r_cmd == stkc_pkg::CMD_SUB ||
                             r_cmd == stkc_pkg::CMD_MUL || r_cmd == stkc_pkg::CMD_DIV) begin
                    priority if (r_count < CW'(2)) begin
                        n_status = stkc_pkg::ST_FEW;
                    end else if (r_cmd == stkc_pkg::CMD_DIV && w_next == '0) begin
                        n_status = stkc_pkg::ST_DIVZ;
                    end else if (r_cmd == stkc_pkg::CMD_DIV) begin
                        w_div_start = 1'b1;
                        n_done      = 1'b0;
                        n_state     = S_DIV;
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end else if (r_cmd == stkc_pkg::CMD_PRINT) begin
                    if (r_count < CW'(1)) begin
                        n_status = stkc_pkg::ST_FEW;
                    end else begin
                        n_count   = r_count - CW'(1);
                        n_printed = 1'b1;
                        n_pval    = w_top;
                        n_ptag    = w_rd_top[EW-1:DW];
                    end
                end else begin
                    n_status = stkc_pkg::ST_BAD;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_we      = 1'b1;
                    w_wdata   = {r_cmd, w_quot};
                    n_count   = r_count - CW'(1);
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_done) begin
            n_depth = stkc_pkg::DEPTH_W'(n_count);
        end
    end

    // state and registered result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_done    <= n_done;
            r_cmd     <= n_cmd;
            r_operand <= n_operand;
            r_status  <= n_status;
            r_printed <= n_printed;
            r_pval    <= n_pval;
            r_ptag    <= n_ptag;
            r_depth   <= n_depth;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_printed     = r_printed;
    assign o_print_value = r_pval;
    assign o_print_tag   = r_ptag;
    assign o_depth       = r_depth;

endmodule

`default_nettype wire

// ----- src/stkc_checker.sv -----
// ---------------------------------------------------------------------------
// stkc_checker
// port-level checks of the stack calculator, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "stack_calculator_core_top_macros.svh"

module stkc_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              o_done,
    input wire logic [stkc_pkg::STATUS_W-1:0]     o_status,
    input wire logic                              o_printed,
    input wire logic [stkc_pkg::DATA_W-1:0]       o_print_value,
    input wire logic [stkc_pkg::TAG_W-1:0]        o_print_tag
);

    // an accepted command keeps the block busy in the next cycle
    `SCC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // a result beat ends the busy period
    `SCC_ASSERT_NOW(a_done_idle, o_done, !busy && $past(busy))

    // a print beat is always a successful one
    `SCC_ASSERT_NOW(a_print_ok, o_done && o_printed, o_status == stkc_pkg::ST_OK)

    // a beat without a print carries zero print fields
    `SCC_ASSERT_NOW(a_noprint_zero, o_done && !o_printed, o_print_value == '0 && o_print_tag == '0)

endmodule

bind stack_calculator_core_top stkc_checker u_stkc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_printed     (o_printed),
    .o_print_value (o_print_value),
    .o_print_tag   (o_print_tag)
);

`default_nettype wire
